// File: hdl/arxdf_pkg.sv
package arxdf_pkg;

   localparam int NUM_B_TAPS   = 4;
   localparam int NUM_A_TAPS   = 3;
   localparam int MAX_DELAY    = 7;
   localparam int SAMPLE_WIDTH = 16;

   localparam int COEF_WIDTH      = 18;
   localparam int FRAC_BITS       = 14;
   localparam int DELAY_WIDTH     = 3;
   localparam int CFG_B_REGS      = 4;
   localparam int CFG_A_REGS      = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = COEF_WIDTH;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_COEF_B0     = csr_index_type'(0);
   localparam csr_index_type REG_COEF_A1     = csr_index_type'(CFG_B_REGS);
   localparam csr_index_type REG_INPUT_DELAY = csr_index_type'(CFG_B_REGS + CFG_A_REGS);

endpackage

// File: hdl/arxdf_csr.sv
module arxdf_csr #(
   parameter int NUM_B_TAPS = arxdf_pkg::NUM_B_TAPS,
   parameter int NUM_A_TAPS = arxdf_pkg::NUM_A_TAPS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          wr_en,
   input  arxdf_pkg::csr_index_type                      wr_index,
   input  logic        [arxdf_pkg::CSR_DATA_WIDTH-1:0]   wr_data,
   output logic signed [arxdf_pkg::COEF_WIDTH-1:0]       coef_b [NUM_B_TAPS],
   output logic signed [arxdf_pkg::COEF_WIDTH-1:0]       coef_a [NUM_A_TAPS],
   output logic        [arxdf_pkg::DELAY_WIDTH-1:0]      delay
);

   logic [arxdf_pkg::DELAY_WIDTH-1:0] delay_ff;

   for (genvar i = 0; i < NUM_B_TAPS; i++) begin : g_b
      if (i < arxdf_pkg::CFG_B_REGS) begin : g_reg
         logic signed [arxdf_pkg::COEF_WIDTH-1:0] coef_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               coef_ff <= '0;
            end else if (wr_en &&
                         wr_index == arxdf_pkg::REG_COEF_B0 +
                                     arxdf_pkg::csr_index_type'(i)) begin
               coef_ff <= wr_data;
            end
         end
         assign coef_b[i] = coef_ff;
      end else begin : g_zero
         assign coef_b[i] = '0;
      end
   end

   for (genvar j = 0; j < NUM_A_TAPS; j++) begin : g_a
      if (j < arxdf_pkg::CFG_A_REGS) begin : g_reg
         logic signed [arxdf_pkg::COEF_WIDTH-1:0] coef_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               coef_ff <= '0;
            end else if (wr_en &&
                         wr_index == arxdf_pkg::REG_COEF_A1 +
                                     arxdf_pkg::csr_index_type'(j)) begin
               coef_ff <= wr_data;
            end
         end
         assign coef_a[j] = coef_ff;
      end else begin : g_zero
         assign coef_a[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else if (wr_en && wr_index == arxdf_pkg::REG_INPUT_DELAY) begin
         delay_ff <= wr_data[arxdf_pkg::DELAY_WIDTH-1:0];
      end
   end

   assign delay = delay_ff;

endmodule

// File: hdl/arxdf_datapath.sv
module arxdf_datapath #(
   parameter int NUM_B_TAPS   = arxdf_pkg::NUM_B_TAPS,
   parameter int NUM_A_TAPS   = arxdf_pkg::NUM_A_TAPS,
   parameter int MAX_DELAY    = arxdf_pkg::MAX_DELAY,
   parameter int SAMPLE_WIDTH = arxdf_pkg::SAMPLE_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic signed [SAMPLE_WIDTH-1:0]           sample,
   input  logic signed [arxdf_pkg::COEF_WIDTH-1:0]  coef_b [NUM_B_TAPS],
   input  logic signed [arxdf_pkg::COEF_WIDTH-1:0]  coef_a [NUM_A_TAPS],
   input  logic        [arxdf_pkg::DELAY_WIDTH-1:0] delay,
   output logic signed [SAMPLE_WIDTH-1:0]           result
);

   localparam int HIST_DEPTH = MAX_DELAY + NUM_B_TAPS;
   localparam int OLD_DEPTH  = (HIST_DEPTH > 1) ? HIST_DEPTH - 1 : 1;
   localparam int PROD_W     = SAMPLE_WIDTH + arxdf_pkg::COEF_WIDTH;
   localparam int ACC_W      = PROD_W + $clog2(NUM_B_TAPS + NUM_A_TAPS) + 1;
   localparam int SHIFT_W    = ACC_W - arxdf_pkg::FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(1) << (arxdf_pkg::FRAC_BITS - 1);
   localparam logic signed [SHIFT_W-1:0] SAT_HI =
      SHIFT_W'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
   localparam logic signed [SHIFT_W-1:0] SAT_LO =
      SHIFT_W'($signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}));

   logic signed [SAMPLE_WIDTH-1:0] hist_ff  [OLD_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] yhist_ff [NUM_A_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] win      [HIST_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] tap      [NUM_B_TAPS];
   logic signed [PROD_W-1:0]       prod_b   [NUM_B_TAPS];
   logic signed [PROD_W-1:0]       prod_a   [NUM_A_TAPS];
   logic signed [ACC_W-1:0]        acc;
   logic signed [ACC_W-1:0]        rounded;
   logic signed [SHIFT_W-1:0]      shifted;

   // window slot k holds u[n-k]
   for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_win
      if (k == 0) begin : g_new
         assign win[k] = sample;
      end else begin : g_old
         assign win[k] = hist_ff[k-1];
      end
   end

   // delay select per tap; delay beyond MAX_DELAY clamps
   for (genvar i = 0; i < NUM_B_TAPS; i++) begin : g_tap
      always_comb begin
         tap[i] = '0;
         for (int j = 0; j <= MAX_DELAY; j++) begin
            if ((j == MAX_DELAY && int'(delay) >= j) || int'(delay) == j) begin
               tap[i] = win[i + j];
            end
         end
      end
      assign prod_b[i] = coef_b[i] * tap[i];
   end

   for (genvar j = 0; j < NUM_A_TAPS; j++) begin : g_fb
      assign prod_a[j] = coef_a[j] * yhist_ff[j];
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NUM_B_TAPS; i++) begin
         acc = acc + ACC_W'(prod_b[i]);
      end
      for (int j = 0; j < NUM_A_TAPS; j++) begin
         acc = acc - ACC_W'(prod_a[j]);
      end
   end

   assign rounded = acc + ROUND_HALF;
   assign shifted = SHIFT_W'(rounded >>> arxdf_pkg::FRAC_BITS);

   always_comb begin
      priority if (shifted > SAT_HI) begin
         result = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         result = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         result = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < OLD_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         for (int j = 0; j < NUM_A_TAPS; j++) begin
            yhist_ff[j] <= '0;
         end
      end else if (advance) begin
         hist_ff[0] <= sample;
         for (int k = 1; k < OLD_DEPTH; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
         yhist_ff[0] <= result;
         for (int j = 1; j < NUM_A_TAPS; j++) begin
            yhist_ff[j] <= yhist_ff[j-1];
         end
      end
   end

endmodule

// File: hdl/arx_delay_iir_filter.sv
// ARX plant model with input dead time: y[n] = sum b_i*u[n-d-i] - sum a_j*y[n-j],
// Q4.14 coefficients (already normalized by the leading denominator term),
// result rounded half up, shifted right by 14 and saturated to SAMPLE_WIDTH.
// One sample per clock sustained while rsp_stall is low: a sample sits in the
// input register, the whole sum of products and the y[n-1] feedback close
// combinationally into the result register behind rsp_valid. While a result
// waits on rsp_stall the input register holds and takes a sample only when
// empty. Input and output history reset to zero; coefficients and input_delay
// reset to zero and are written through the csr port (always ready); the user
// must write them only while no sample is in flight, which the block leaves
// unchecked. Delays above MAX_DELAY clamp to MAX_DELAY.
module arx_delay_iir_filter #(
   parameter int NUM_B_TAPS   = arxdf_pkg::NUM_B_TAPS,
   parameter int NUM_A_TAPS   = arxdf_pkg::NUM_A_TAPS,
   parameter int MAX_DELAY    = arxdf_pkg::MAX_DELAY,
   parameter int SAMPLE_WIDTH = arxdf_pkg::SAMPLE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_sample_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  arxdf_pkg::csr_index_type               csr_index,
   input  logic [arxdf_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]          in_sample_ff;
   logic                                    out_valid_ff;
   logic                                    out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]          out_sample_ff;
   logic                                    advance;
   logic                                    load;
   logic signed [SAMPLE_WIDTH-1:0]          result;
   logic signed [arxdf_pkg::COEF_WIDTH-1:0] coef_b [NUM_B_TAPS];
   logic signed [arxdf_pkg::COEF_WIDTH-1:0] coef_a [NUM_A_TAPS];
   logic [arxdf_pkg::DELAY_WIDTH-1:0]       delay;

   assign csr_ready = 1'b1;

   arxdf_csr #(
      .NUM_B_TAPS (NUM_B_TAPS),
      .NUM_A_TAPS (NUM_A_TAPS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .coef_b   (coef_b),
      .coef_a   (coef_a),
      .delay    (delay)
   );

   // input register moves when the result register is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;

   assign in_valid_in  = load | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   arxdf_datapath #(
      .NUM_B_TAPS   (NUM_B_TAPS),
      .NUM_A_TAPS   (NUM_A_TAPS),
      .MAX_DELAY    (MAX_DELAY),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_sample_ff),
      .coef_b  (coef_b),
      .coef_a  (coef_a),
      .delay   (delay),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_sample_ff <= req_sample_in;
      end
      if (advance) begin
         out_sample_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled while result register could drain");

   a_pending_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !(out_valid_ff && rsp_stall)) |=> rsp_valid)
      else $error("pending sample did not reach result register");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule
